>>> design/assert_macros.svh
// Assertion macros shared by the excursion run detector RTL.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside of reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/erd_pkg.sv
// Package for the excursion run detector: widths, register map and shared types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package erd_pkg;

  localparam int unsigned INDEX_BITS   = 16;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned RUN_LEN_W    = 5;
  localparam int unsigned RUN_CNT_W    = 5;
  localparam int unsigned MID_W        = 4;
  localparam int unsigned OUT_TDATA_W  = ((INDEX_BITS + 7) / 8) * 8;
  localparam int unsigned APB_ADDR_W   = 4;
  localparam int unsigned APB_DATA_W   = 32;

  localparam logic [RUN_LEN_W-1:0] RUN_LEN_RESET = RUN_LEN_W'(4);
  localparam logic [RUN_LEN_W-1:0] RUN_LEN_MAX   = RUN_LEN_W'(16);
  localparam logic [RUN_CNT_W-1:0] RUN_CNT_SAT   = '1;

  localparam logic [1:0] REG_UPPER   = 2'd0;
  localparam logic [1:0] REG_LOWER   = 2'd1;
  localparam logic [1:0] REG_RUN_LEN = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] upper_threshold;
    logic signed [SAMPLE_W-1:0] lower_threshold;
    logic [RUN_LEN_W-1:0]       run_length;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic qbit;
  } quant_t;

  typedef struct packed {
    logic                  emit;
    logic [INDEX_BITS-1:0] run_index;
    logic                  run_bit;
  } result_t;

endpackage

`default_nettype wire

>>> design/erd_cfg_regs.sv
// Configuration register file of the excursion run detector, APB write and read.
// Depends on erd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erd_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [erd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [erd_pkg::APB_DATA_W-1:0] pwdata,
  output      logic [erd_pkg::APB_DATA_W-1:0] prdata,
  output      logic                           pready,
  output      erd_pkg::cfg_t                  cfg_o
);

  erd_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]    reg_sel;
  logic          wr_en;

  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        erd_pkg::REG_UPPER:   cfg_d.upper_threshold = pwdata[erd_pkg::SAMPLE_W-1:0];
        erd_pkg::REG_LOWER:   cfg_d.lower_threshold = pwdata[erd_pkg::SAMPLE_W-1:0];
        erd_pkg::REG_RUN_LEN: cfg_d.run_length      = pwdata[erd_pkg::RUN_LEN_W-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      erd_pkg::REG_UPPER: begin
        prdata = {{(erd_pkg::APB_DATA_W-erd_pkg::SAMPLE_W){cfg_q.upper_threshold[15]}},
                  cfg_q.upper_threshold};
      end
      erd_pkg::REG_LOWER: begin
        prdata = {{(erd_pkg::APB_DATA_W-erd_pkg::SAMPLE_W){cfg_q.lower_threshold[15]}},
                  cfg_q.lower_threshold};
      end
      erd_pkg::REG_RUN_LEN: begin
        prdata = {{(erd_pkg::APB_DATA_W-erd_pkg::RUN_LEN_W){1'b0}}, cfg_q.run_length};
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.upper_threshold <= '0;
      cfg_q.lower_threshold <= '0;
      cfg_q.run_length      <= erd_pkg::RUN_LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

>>> design/erd_quantizer.sv
// Two-threshold quantizer: maps one signed sample to bit one, bit zero or invalid.
// Depends on erd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erd_quantizer (
  input  wire logic signed [erd_pkg::SAMPLE_W-1:0] sample_i,
  input  wire erd_pkg::cfg_t                       cfg_i,
  output      erd_pkg::quant_t                     quant_o
);

  logic above;
  logic below;

  assign above = sample_i > cfg_i.upper_threshold;
  assign below = sample_i < cfg_i.lower_threshold;

  // Bit one wins when both thresholds are crossed at once.
  assign quant_o.valid = above || below;
  assign quant_o.qbit  = above;

endmodule

`default_nettype wire

>>> design/erd_run_tracker.sv
// Run state of the excursion run detector: sample index, run start, count and bit.
// Produces the midpoint result for each processed sample. Depends on erd_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module erd_run_tracker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire erd_pkg::quant_t                quant_i,
  input  wire logic [erd_pkg::RUN_LEN_W-1:0]  run_length_i,
  output      erd_pkg::result_t               result_o
);

  logic [erd_pkg::INDEX_BITS:0]   sample_index_q, sample_index_d;
  logic [erd_pkg::INDEX_BITS-1:0] run_start_q, run_start_d;
  logic [erd_pkg::RUN_CNT_W-1:0]  run_count_q, run_count_d;
  logic                           current_bit_q, current_bit_d;

  logic                           idx_full;
  logic                           extend;
  logic [erd_pkg::RUN_LEN_W-1:0]  eff_len;
  logic [erd_pkg::RUN_LEN_W-1:0]  len_m1;
  logic [erd_pkg::MID_W-1:0]      mid_off;
  logic [erd_pkg::RUN_CNT_W-1:0]  new_count;
  logic [erd_pkg::INDEX_BITS-1:0] new_start;
  logic                           emit;

  assign idx_full = sample_index_q[erd_pkg::INDEX_BITS];
  assign extend   = (run_count_q != '0) && (quant_i.qbit == current_bit_q);

  always_comb begin
    if (run_length_i == '0) begin
      eff_len = erd_pkg::RUN_LEN_W'(1);
    end else if (run_length_i > erd_pkg::RUN_LEN_MAX) begin
      eff_len = erd_pkg::RUN_LEN_MAX;
    end else begin
      eff_len = run_length_i;
    end
  end

  assign len_m1  = eff_len - erd_pkg::RUN_LEN_W'(1);
  assign mid_off = len_m1[erd_pkg::MID_W:1];

  always_comb begin
    if (extend) begin
      new_count = (run_count_q == erd_pkg::RUN_CNT_SAT) ? run_count_q
                                                        : run_count_q + 1'b1;
      new_start = run_start_q;
    end else begin
      new_count = erd_pkg::RUN_CNT_W'(1);
      new_start = sample_index_q[erd_pkg::INDEX_BITS-1:0];
    end
  end

  assign emit = step_i && !idx_full && quant_i.valid && (new_count >= eff_len);

  always_comb begin
    sample_index_d = sample_index_q;
    run_start_d    = run_start_q;
    run_count_d    = run_count_q;
    current_bit_d  = current_bit_q;
    if (step_i && !idx_full) begin
      sample_index_d = sample_index_q + 1'b1;
      if (!quant_i.valid) begin
        run_count_d = '0;
      end else begin
        run_start_d   = new_start;
        current_bit_d = quant_i.qbit;
        run_count_d   = emit ? '0 : new_count;
      end
    end
  end

  assign result_o.emit      = emit;
  assign result_o.run_index = new_start + erd_pkg::INDEX_BITS'(mid_off);
  assign result_o.run_bit   = quant_i.qbit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_index_q <= '0;
      run_start_q    <= '0;
      run_count_q    <= '0;
      current_bit_q  <= 1'b0;
    end else begin
      sample_index_q <= sample_index_d;
      run_start_q    <= run_start_d;
      run_count_q    <= run_count_d;
      current_bit_q  <= current_bit_d;
    end
  end

  `ASSERT_ALWAYS(a_count_bounded, run_count_q <= erd_pkg::RUN_CNT_W'(erd_pkg::RUN_LEN_MAX))
  `ASSERT_NEXT(a_index_stays_full, idx_full, idx_full && $stable(run_count_q))
  `ASSERT_NEXT(a_emit_clears_run, emit, run_count_q == '0)
  `ASSERT_IMPLY(a_emit_needs_step, emit, step_i && quant_i.valid)

endmodule

`default_nettype wire

>>> design/excursion_run_detector_top.sv
// Top level of the excursion run detector: input register, quantizer, run tracker,
// result register and APB configuration. Depends on erd_pkg and the erd_* modules.
//
//   Channel   Dir  Handshake                 Payload
//   s_axis    in   s_axis_tvalid/tready      tdata[15:0] = sample
//   m_axis    out  m_axis_tvalid/tready      tdata = run_index, tuser[0] = run_bit
//   apb       in   psel/penable/pready       registers at 0x0, 0x4, 0x8
//
// One sample is accepted every cycle while the result register is not stalled; an
// accepted sample is held in the input register, which feeds the result register.
// The run state updates as a sample moves from the input register to the result stage.
// A stalled result register holds the next sample in the input register only.
// Reset is asynchronous and active low; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module excursion_run_detector_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [erd_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] sample
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output      logic [erd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // run_index from bit 0
  output      logic                            m_axis_tuser,   // [0] run_bit
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [erd_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [erd_pkg::APB_DATA_W-1:0]  pwdata,
  output      logic [erd_pkg::APB_DATA_W-1:0]  prdata,
  output      logic                            pready
);

  erd_pkg::cfg_t    cfg;
  erd_pkg::quant_t  quant;
  erd_pkg::result_t result;

  logic                                in_valid_q;
  logic signed [erd_pkg::SAMPLE_W-1:0] in_sample_q;
  logic                                out_valid_q;
  logic [erd_pkg::INDEX_BITS-1:0]      out_index_q;
  logic                                out_bit_q;
  logic                                out_free;
  logic                                advance;
  logic                                in_take;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  erd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  erd_quantizer u_quant (
    .sample_i (in_sample_q),
    .cfg_i    (cfg),
    .quant_o  (quant)
  );

  erd_run_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .quant_i      (quant),
    .run_length_i (cfg.run_length),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= result.emit;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_sample_q <= s_axis_tdata;
    end
    if (advance && result.emit) begin
      out_index_q <= result.run_index;
      out_bit_q   <= result.run_bit;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = erd_pkg::OUT_TDATA_W'(out_index_q);
  assign m_axis_tuser  = out_bit_q;

  `ASSERT_NEXT(a_in_held, in_valid_q && !advance, in_valid_q && $stable(in_sample_q))
  `ASSERT_IMPLY(a_advance_room, advance, !out_valid_q || m_axis_tready)
  `ASSERT_NEXT(a_result_held, out_valid_q && !m_axis_tready,
               out_valid_q && $stable(out_index_q) && $stable(out_bit_q))

endmodule

`default_nettype wire
